FILE: hw/rtl/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  // operation codes
  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_MAG = 3'd4;
  localparam logic [2:0] FUNC_EQ  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // quotient bits per divider (and root bits per square root)
  localparam int STEPS = 33;

  // payload handed from cell to cell
  typedef struct packed {
    logic [2:0]  func;
    logic        is_eq;
    logic [31:0] rr;      // early result for add, sub, mul and the rest
    logic [31:0] ri;
    logic [1:0]  st;
    logic        neg_r;
    logic        neg_i;
    logic        sat_r;   // quotient already known to be too large
    logic        sat_i;
    logic        dz;      // divisor is zero
    logic [63:0] d;
    logic [63:0] rem_r;
    logic [63:0] rem_i;
    logic [63:0] rem_s;
    logic [32:0] q_r;
    logic [32:0] q_i;
    logic [32:0] root;
    logic [32:0] nlo_r;   // dividend bits still to be brought down
    logic [32:0] nlo_i;
  } cau_lane_t;

  // sign and magnitude to saturated 32-bit value, {sat, value}
  function automatic logic [32:0] to_q(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(64'd0 - mag)};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cau_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module cau_cell import cau_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        en,
  input  wire        in_valid,
  input  cau_lane_t  in_lane,
  output logic       out_valid,
  output cau_lane_t  out_lane
);

  cau_lane_t  lane_next;
  logic [63:0] tr_r;
  logic [63:0] tr_i;
  logic [65:0] tr_s;

  // one restoring step on each divider and one root bit
  always_comb begin
    lane_next = in_lane;
    tr_r = {in_lane.rem_r[62:0], in_lane.nlo_r[32]};
    tr_i = {in_lane.rem_i[62:0], in_lane.nlo_i[32]};
    lane_next.nlo_r = {in_lane.nlo_r[31:0], 1'b0};
    lane_next.nlo_i = {in_lane.nlo_i[31:0], 1'b0};
    if (tr_r >= in_lane.d) begin
      lane_next.rem_r = tr_r - in_lane.d;
      lane_next.q_r = {in_lane.q_r[31:0], 1'b1};
    end else begin
      lane_next.rem_r = tr_r;
      lane_next.q_r = {in_lane.q_r[31:0], 1'b0};
    end
    if (tr_i >= in_lane.d) begin
      lane_next.rem_i = tr_i - in_lane.d;
      lane_next.q_i = {in_lane.q_i[31:0], 1'b1};
    end else begin
      lane_next.rem_i = tr_i;
      lane_next.q_i = {in_lane.q_i[31:0], 1'b0};
    end
    tr_s = ({33'd0, in_lane.root} << (BIT + 1)) | (66'd1 << (2 * BIT));
    if ({2'b00, in_lane.rem_s} >= tr_s) begin
      lane_next.rem_s = in_lane.rem_s - tr_s[63:0];
      lane_next.root = in_lane.root | (33'd1 << BIT);
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Complex arithmetic unit on signed fixed-point operands.
// Input channel s_*: one transaction carries an operation code in s_tuser and
// operands A and B in s_tdata. Output channel m_*: one result transaction per
// input, real and imaginary parts in m_tdata, equal flag and status in m_tuser.
// Operations: add, subtract, multiply, divide, magnitude of A, equality test.
// Results come out in input order. One transaction is taken every cycle while
// the output is not stalled: the pipeline is four front stages (products, sums,
// magnitudes, divider setup), a row of 33 cells that each resolve one quotient
// bit of both dividers and one root bit, and the output register.
// Reset clears all valid flags; no result is pending afterwards.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready drops until the result is taken.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [127:0] s_tdata,   // a_real, a_imag, b_real, b_imag
  input  wire  [2:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [63:0]  m_tdata,   // res_real, res_imag
  output logic [2:0]   m_tuser    // is_equal, status
);

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [31:0] ar, ai, br, bi;
  assign ar = s_tdata[31:0];
  assign ai = s_tdata[63:32];
  assign br = s_tdata[95:64];
  assign bi = s_tdata[127:96];

  // stage 1: products and add/sub
  logic               v1;
  logic [2:0]         f1;
  logic               eq1;
  logic signed [63:0] p_arbr, p_aibi, p_arbi, p_aibr, p_brbr, p_bibi, p_arar, p_aiai;
  logic [31:0]        rr1, ri1;
  logic [1:0]         st1;
  logic [32:0]        sum_r, sum_i;
  logic [31:0]        rr1_next, ri1_next;
  logic [1:0]         st1_next;

  always_comb begin
    rr1_next = 32'd0;
    ri1_next = 32'd0;
    st1_next = ST_OK;
    if (s_tuser == FUNC_SUB) begin
      sum_r = {ar[31], ar} - {br[31], br};
      sum_i = {ai[31], ai} - {bi[31], bi};
    end else begin
      sum_r = {ar[31], ar} + {br[31], br};
      sum_i = {ai[31], ai} + {bi[31], bi};
    end
    if (s_tuser == FUNC_ADD || s_tuser == FUNC_SUB) begin
      rr1_next = sum_r[31:0];
      ri1_next = sum_i[31:0];
      if (sum_r[32] != sum_r[31]) begin
        rr1_next = sum_r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        st1_next = ST_SAT;
      end
      if (sum_i[32] != sum_i[31]) begin
        ri1_next = sum_i[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        st1_next = ST_SAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      f1 <= s_tuser;
      eq1 <= (ar == br) && (ai == bi);
      p_arbr <= ar * br;
      p_aibi <= ai * bi;
      p_arbi <= ar * bi;
      p_aibr <= ai * br;
      p_brbr <= br * br;
      p_bibi <= bi * bi;
      p_arar <= ar * ar;
      p_aiai <= ai * ai;
      rr1 <= rr1_next;
      ri1 <= ri1_next;
      st1 <= st1_next;
    end
  end

  // stage 2: sums of products
  logic               v2;
  logic [2:0]         f2;
  logic               eq2;
  logic [31:0]        rr2, ri2;
  logic [1:0]         st2;
  logic signed [64:0] num_r, num_i;
  logic [63:0]        d2, s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      f2 <= f1;
      eq2 <= eq1;
      rr2 <= rr1;
      ri2 <= ri1;
      st2 <= st1;
      if (f1 == FUNC_MUL) begin
        num_r <= {p_arbr[63], p_arbr} - {p_aibi[63], p_aibi};
        num_i <= {p_arbi[63], p_arbi} + {p_aibr[63], p_aibr};
      end else begin
        num_r <= {p_arbr[63], p_arbr} + {p_aibi[63], p_aibi};
        num_i <= {p_aibr[63], p_aibr} - {p_arbi[63], p_arbi};
      end
      d2 <= p_brbr + p_bibi;
      s2 <= p_arar + p_aiai;
    end
  end

  // stage 3: sign and magnitude
  logic        v3;
  logic [2:0]  f3;
  logic        eq3;
  logic [31:0] rr3, ri3;
  logic [1:0]  st3;
  logic        neg_r3, neg_i3, dz3;
  logic [63:0] mag_r3, mag_i3, d3, s3;
  logic [64:0] abs_r, abs_i;

  assign abs_r = num_r[64] ? 65'd0 - num_r : num_r;
  assign abs_i = num_i[64] ? 65'd0 - num_i : num_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      f3 <= f2;
      eq3 <= eq2;
      rr3 <= rr2;
      ri3 <= ri2;
      st3 <= st2;
      neg_r3 <= num_r[64];
      neg_i3 <= num_i[64];
      mag_r3 <= abs_r[63:0];
      mag_i3 <= abs_i[63:0];
      d3 <= d2;
      dz3 <= (d2 == 64'd0);
      s3 <= s2;
    end
  end

  // stage 4: product results and divider setup
  logic [64+FRAC_BITS-1:0] nfull_r, nfull_i;
  logic [63:0] hi_r, hi_i;
  logic [32:0] mq_r, mq_i;
  cau_lane_t   lane4_next;

  assign nfull_r = {mag_r3, {FRAC_BITS{1'b0}}};
  assign nfull_i = {mag_i3, {FRAC_BITS{1'b0}}};
  assign hi_r = mag_r3 >> (STEPS - FRAC_BITS);
  assign hi_i = mag_i3 >> (STEPS - FRAC_BITS);
  assign mq_r = to_q(neg_r3, mag_r3 >> FRAC_BITS);
  assign mq_i = to_q(neg_i3, mag_i3 >> FRAC_BITS);

  always_comb begin
    lane4_next.func = f3;
    lane4_next.is_eq = eq3;
    lane4_next.rr = rr3;
    lane4_next.ri = ri3;
    lane4_next.st = st3;
    if (f3 == FUNC_MUL) begin
      lane4_next.rr = mq_r[31:0];
      lane4_next.ri = mq_i[31:0];
      lane4_next.st = (mq_r[32] || mq_i[32]) ? ST_SAT : ST_OK;
    end
    lane4_next.neg_r = neg_r3;
    lane4_next.neg_i = neg_i3;
    lane4_next.sat_r = (hi_r >= d3);
    lane4_next.sat_i = (hi_i >= d3);
    lane4_next.dz = dz3;
    lane4_next.d = d3;
    lane4_next.rem_r = hi_r;
    lane4_next.rem_i = hi_i;
    lane4_next.rem_s = s3;
    lane4_next.q_r = 33'd0;
    lane4_next.q_i = 33'd0;
    lane4_next.root = 33'd0;
    lane4_next.nlo_r = nfull_r[STEPS-1:0];
    lane4_next.nlo_i = nfull_i[STEPS-1:0];
  end

  logic      vc [0:STEPS];
  cau_lane_t lc [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc[0] <= 1'b0;
    end else if (en) begin
      vc[0] <= v3;
    end
    if (en) begin
      lc[0] <= lane4_next;
    end
  end

  // row of cells, quotient and root bits from the top down
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    cau_cell #(.BIT(STEPS - 1 - k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (vc[k]),
      .in_lane  (lc[k]),
      .out_valid(vc[k+1]),
      .out_lane (lc[k+1])
    );
  end

  // final selection
  cau_lane_t   lf;
  logic [32:0] dv_r, dv_i, dq_r, dq_i, sq;
  logic [31:0] res_r, res_i;
  logic [1:0]  res_st;

  assign lf = lc[STEPS];
  assign dv_r = lf.sat_r ? 33'h1_0000_0000 : lf.q_r;
  assign dv_i = lf.sat_i ? 33'h1_0000_0000 : lf.q_i;
  assign dq_r = to_q(lf.neg_r, {31'd0, dv_r});
  assign dq_i = to_q(lf.neg_i, {31'd0, dv_i});
  assign sq = to_q(1'b0, {31'd0, lf.root});

  always_comb begin
    res_r = lf.rr;
    res_i = lf.ri;
    res_st = lf.st;
    case (lf.func)
      FUNC_DIV: begin
        if (lf.dz) begin
          res_r = 32'd0;
          res_i = 32'd0;
          res_st = ST_DIV0;
        end else begin
          res_r = dq_r[31:0];
          res_i = dq_i[31:0];
          res_st = (dq_r[32] || dq_i[32]) ? ST_SAT : ST_OK;
        end
      end
      FUNC_MAG: begin
        res_r = sq[31:0];
        res_i = 32'd0;
        res_st = sq[32] ? ST_SAT : ST_OK;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vc[STEPS];
    end
    if (en) begin
      m_tdata <= {res_i, res_r};
      m_tuser <= {res_st, lf.is_eq};
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/complex_arithmetic_unit_checker.sv
`timescale 1ns / 1ps

module complex_arithmetic_unit_checker import cau_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  input  wire          s_tready,
  input  wire  [127:0] s_tdata,
  input  wire  [2:0]   s_tuser,
  input  wire          m_tvalid,
  input  wire          m_tready,
  input  wire  [63:0]  m_tdata,
  input  wire  [2:0]   m_tuser,
  output int           errors,
  output int           pending,
  output int           results_seen
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  st;
  } cplx_result_t;

  localparam int FB = 16;

  cplx_result_t expected_results[$];

  // clamp a wide signed value to 32 bits
  function automatic logic [31:0] clamp_q(input logic signed [129:0] v, inout logic [1:0] st);
    if (v > 130'sd2147483647) begin
      st = ST_SAT;
      return 32'h7FFF_FFFF;
    end
    if (v < -130'sd2147483648) begin
      st = ST_SAT;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // truncate toward zero: num * 2^FB / den
  function automatic logic signed [129:0] div_trunc(input logic signed [129:0] num,
                                                     input logic signed [129:0] den);
    logic signed [129:0] n;
    logic signed [129:0] q;
    n = num <<< FB;
    q = (n < 0) ? -((-n) / den) : n / den;
    return q;
  endfunction

  function automatic cplx_result_t complex_op(input logic [2:0] op, input logic [127:0] d);
    logic signed [129:0] ar, ai, br, bi, x, y, den, s;
    logic [129:0] root, bitv;
    cplx_result_t r;
    ar = $signed(d[31:0]);
    ai = $signed(d[63:32]);
    br = $signed(d[95:64]);
    bi = $signed(d[127:96]);
    r = '0;
    r.eq = (ar == br) && (ai == bi);
    case (op)
      FUNC_ADD: begin
        r.re = clamp_q(ar + br, r.st);
        r.im = clamp_q(ai + bi, r.st);
      end
      FUNC_SUB: begin
        r.re = clamp_q(ar - br, r.st);
        r.im = clamp_q(ai - bi, r.st);
      end
      FUNC_MUL: begin
        // products are truncated toward zero after the shift
        x = ar * br - ai * bi;
        y = ar * bi + ai * br;
        x = (x < 0) ? -((-x) >>> FB) : x >>> FB;
        y = (y < 0) ? -((-y) >>> FB) : y >>> FB;
        r.re = clamp_q(x, r.st);
        r.im = clamp_q(y, r.st);
      end
      FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.st = ST_DIV0;
        else begin
          r.re = clamp_q(div_trunc(ar * br + ai * bi, den), r.st);
          r.im = clamp_q(div_trunc(ai * br - ar * bi, den), r.st);
        end
      end
      FUNC_MAG: begin
        s = ar * ar + ai * ai;
        root = 0;
        bitv = 130'd1 << 64;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
          if (s >= root + bitv) begin
            s = s - (root + bitv);
            root = (root >> 1) + bitv;
          end else root = root >> 1;
          bitv = bitv >> 2;
        end
        r.re = clamp_q(root, r.st);
      end
      default: ;
    endcase
    return r;
  endfunction

  cplx_result_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(complex_op(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[2:1]};
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            $display("%0t: mismatch re exp %h got %h, im exp %h got %h, eq exp %b got %b, st exp %0d got %0d",
                     $time, want.re, got.re, want.im, got.im, want.eq, got.eq, want.st, got.st);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = expected_results.size();

endmodule

FILE: tb/sv/complex_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb import cau_pkg::*;;

  localparam int RANDOM_ITEMS = 1950;
  localparam int WATCHDOG_LIMIT = 5000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [2:0]   m_tuser;
  int           errors, pending, results_seen;
  bit           calm = 1'b0;
  bit           hold_off = 1'b0;
  int           idle_cycles = 0;
  int           rx_idle = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  complex_arithmetic_unit dut (.*);

  complex_arithmetic_unit_checker chk (.*);

  // operand values biased towards edges
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3, 4: return 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
      5: return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction and wait for it to be taken
  task automatic send_op(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {bi, br, ai, ar};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receiver: stalls in random bursts, one long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else if (rx_idle > 0) begin
      m_tready <= 1'b0;
      rx_idle <= rx_idle - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      rx_idle <= $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on accepted transactions
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else if (!rst) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("** complex_arithmetic_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [31:0] v;
    int wait_cnt;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_op(FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_op(FUNC_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
    send_op(FUNC_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_op(FUNC_SUB, 32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 32'h0001_0000);
    send_op(FUNC_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    send_op(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op(FUNC_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(FUNC_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
    send_op(FUNC_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_op(FUNC_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_op(FUNC_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
    send_op(FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op(FUNC_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(FUNC_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_op(FUNC_MAG, 32'h0003_0000, 32'hFFFC_0000, 32'h1, 32'h2);
    send_op(FUNC_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(FUNC_EQ, 32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321);
    send_op(FUNC_EQ, 32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4320);
    send_op(3'd6, 32'h1, 32'h2, 32'h1, 32'h2);
    send_op(3'd7, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (80) send_op(3'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                          pick_operand(), pick_operand());
    join

    // random operations, some with A copied into B
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 200) calm = 1'b1;
      v = pick_operand();
      if ($urandom_range(0, 7) == 0)
        send_op(3'($urandom_range(0, 7)), v, v ^ 32'h1, v, v ^ 32'h1);
      else
        send_op(3'($urandom_range(0, 7)), v, pick_operand(), pick_operand(), pick_operand());
    end
    s_tvalid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    $display("covered %0d results over all operation codes, saturation and divide by zero",
             results_seen);
    $display("including a %0d-cycle receiver hold-off with the input backed up", 200);
    if (errors == 0 && pending == 0) $display("** complex_arithmetic_unit: PASSED **");
    else $display("** complex_arithmetic_unit: FAILED **");
    $finish;
  end

endmodule
